FILE: hw/rtl/sfi_pkg.sv
// Package: shared constants, types and codes of the fuzzy inference block.
package sfi_pkg;

    localparam int MAX_RULES_DEF = 16;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_CLEAR = 2'd1,
        K_EVAL  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_RULE = 2'd1,
        ST_FULL    = 2'd2,
        ST_ZERO_W  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MEM,
        S_QDIV,
        S_MUL,
        S_ACC,
        S_FDIV,
        S_FIN,
        S_OUT
    } t_state;

    // Divider control: start strobe and operands, busy and done back.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        logic signed [31:0] r;
        if (v > 80'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -80'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/sfi_if.sv
// Interfaces: valid/ready channels for request and result items.
interface sfi_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] sample_x;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic signed [31:0] slope;
    logic signed [31:0] offset;
    modport source (output valid, kind, sample_x, range_low, range_high, slope, offset,
                    input ready);
    modport sink   (input valid, kind, sample_x, range_low, range_high, slope, offset,
                    output ready);
endinterface

interface sfi_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_y;
    logic [1:0]         status;
    logic               result_valid;
    modport source (output valid, result_y, status, result_valid, input ready);
    modport sink   (input valid, result_y, status, result_valid, output ready);
endinterface

FILE: hw/rtl/sfi_div.sv
// Shared unsigned 64-bit restoring divider, one quotient bit per cycle.
module sfi_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfi_pkg::t_div_req i_req,
    output sfi_pkg::t_div_rsp o_rsp
);
    import sfi_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_dsr, n_dsr;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_trial;
    logic [64:0] w_sub;

    // One shift-subtract step.
    always_comb begin
        w_trial = {r_rem, r_quo[63]};
        w_sub   = w_trial - {1'b0, r_dsr};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[64]) begin
                n_rem = w_sub[63:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_trial[63:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

FILE: hw/rtl/sugeno_fuzzy_inference.sv
// Top level: rule table, sequencer and accumulators of the fuzzy inference block.
//
// Channels: i_req (sink) carries one item: add a rule, clear the table or
// evaluate at sample_x. o_rsp (source) returns exactly one result per item.
// A transfer happens on a clock edge with valid and ready both high.
// Add, clear and the unused kind pass through the finish state before
// o_rsp.valid rises. An evaluate walks the stored rules one at a time through
// one shared 64-bit divider (one quotient bit a cycle): a rule outside its
// support takes the read, start and divide steps, an active rule adds its
// multiply and accumulate steps. The final mean takes the start, divide and
// finish steps, and skips the divide when no rule is active. The next item is
// taken only once the block is back in idle after the result transfer.
// The block takes one item at a time; ready is low until the result has been
// transferred. A stalled receiver simply holds the result in the output
// register and the block waits.
// Reset (synchronous, active low) empties the table and sets the validity
// flag; the rule memory itself is not cleared.
module sugeno_fuzzy_inference #(
    parameter int MAX_RULES = sfi_pkg::MAX_RULES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfi_req_if.sink   i_req,
    sfi_rsp_if.source o_rsp
);
    import sfi_pkg::*;

    localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    // Rule memory: centre, width, slope, offset.
    logic [127:0] r_mem [MAX_RULES];
    logic [127:0] r_rd;

    t_state r_st, n_st;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_lv, n_lv;
    t_kind              r_kind;
    logic signed [31:0] r_x, r_lo, r_hi, r_sl, r_of;
    logic signed [79:0] r_num, n_num;
    logic [36:0]        r_den, n_den;
    logic               r_any, n_any;
    logic [16:0]        r_m, n_m;
    logic signed [63:0] r_prod, n_prod;
    logic signed [31:0] r_y, n_y;
    logic [1:0]         r_stat, n_stat;
    logic               r_neg, n_neg;
    logic               r_ov, n_ov;
    logic               w_wr;
    t_div_req           w_dreq;
    t_div_rsp           w_drsp;

    // Add-path arithmetic.
    logic signed [32:0] w_lo, w_hi, w_s, w_w;
    logic signed [32:0] w_c;
    always_comb begin
        w_lo = (r_lo < r_hi) ? 33'(r_lo) : 33'(r_hi);
        w_hi = (r_lo < r_hi) ? 33'(r_hi) : 33'(r_lo);
        w_s  = w_lo + w_hi;
        w_w  = w_hi - w_lo;
        w_c  = w_s >>> 1;
    end

    // Evaluate-path operands from the read rule.
    logic signed [31:0] w_rc, w_rs, w_ro;
    logic [31:0]        w_rw;
    logic signed [32:0] w_diff;
    logic [32:0]        w_d;
    logic signed [63:0] w_cy;
    logic signed [31:0] w_cys;
    logic [79:0]        w_anum;
    always_comb begin
        w_rc   = r_rd[127:96];
        w_rw   = r_rd[95:64];
        w_rs   = r_rd[63:32];
        w_ro   = r_rd[31:0];
        w_diff = 33'(r_x) - 33'(w_rc);
        w_d    = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
        w_cy   = (r_prod >>> 16) + 64'(w_ro);
        w_cys  = sat32(80'(w_cy));
        w_anum = r_num[79] ? 80'(-r_num) : 80'(r_num);
    end

    assign w_wr = (r_st == S_FIN) && (r_kind == K_ADD) && (w_w != 0)
                  && (r_cnt < CW'(MAX_RULES));

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr)
            r_mem[r_cnt[IW-1:0]] <= {w_c[31:0], w_w[31:0], r_sl, r_of};
        r_rd <= r_mem[r_idx[IW-1:0]];
    end

    sfi_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_req.valid) n_st = (t_kind'(i_req.kind) == K_EVAL) ? S_RD : S_FIN;
            S_RD:   n_st = (r_idx < r_cnt) ? S_MEM : S_FDIV;
            S_MEM:  n_st = S_QDIV;
            S_QDIV: if (w_drsp.done) n_st = (w_drsp.quotient < 64'd65536) ? S_MUL : S_RD;
            S_MUL:  n_st = S_ACC;
            S_ACC:  n_st = S_RD;
            S_FDIV: if (!r_any || w_drsp.done) n_st = S_FIN;
            S_FIN:  n_st = S_OUT;
            S_OUT:  if (o_rsp.ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        n_lv   = r_lv;
        n_num  = r_num;
        n_den  = r_den;
        n_any  = r_any;
        n_m    = r_m;
        n_prod = r_prod;
        n_y    = r_y;
        n_stat = r_stat;
        n_neg  = r_neg;
        n_ov   = r_ov;
        w_dreq = '0;
        unique case (r_st)
            S_IDLE: begin
                n_idx = '0;
                n_num = '0;
                n_den = '0;
                n_any = 1'b0;
            end
            S_RD: begin
                if (!(r_idx < r_cnt) && r_any) begin
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = w_anum[63:0];
                    w_dreq.divisor  = 64'(r_den);
                    n_neg           = r_num[79];
                    n_ov            = |w_anum[79:64];
                end
            end
            S_MEM: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = {15'd0, w_d, 16'd0};
                w_dreq.divisor  = 64'(w_rw);
                n_prod          = 64'(r_x) * 64'(w_rs);
            end
            // Hold the index on this rule until it is done with, so the read stays put
            S_QDIV: begin
                if (w_drsp.done) begin
                    if (w_drsp.quotient < 64'd65536)
                        n_m = 17'(18'd65536 - 18'(w_drsp.quotient[16:0]));
                    else
                        n_idx = r_idx + CW'(1);
                end
            end
            S_MUL: begin
                n_prod = 64'(w_cys) * 64'($signed({1'b0, r_m}));
            end
            S_ACC: begin
                n_num = r_num + 80'(r_prod);
                n_den = r_den + 37'(r_m);
                n_any = 1'b1;
                n_idx = r_idx + CW'(1);
            end
            S_FDIV: ;
            S_FIN: begin
                n_y    = '0;
                n_stat = ST_OK;
                unique case (r_kind)
                    K_ADD: begin
                        if (w_w == 0)
                            n_stat = ST_ZERO_W;
                        else if (!(r_cnt < CW'(MAX_RULES)))
                            n_stat = ST_FULL;
                        else
                            n_cnt = r_cnt + CW'(1);
                    end
                    K_CLEAR: begin
                        n_cnt = '0;
                        n_lv  = 1'b1;
                    end
                    K_EVAL: begin
                        if (r_any) begin
                            n_lv = 1'b1;
                            if (r_ov)
                                n_y = r_neg ? 32'sh80000000 : 32'sh7fffffff;
                            else
                                n_y = sat32(r_neg ? -80'($signed({1'b0, w_drsp.quotient}))
                                                  : 80'($signed({1'b0, w_drsp.quotient})));
                        end else begin
                            n_stat = ST_NO_RULE;
                            n_lv   = 1'b0;
                        end
                    end
                    K_NONE: ;
                    default: ;
                endcase
            end
            S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_req.valid) begin
            r_kind <= t_kind'(i_req.kind);
            r_x    <= i_req.sample_x;
            r_lo   <= i_req.range_low;
            r_hi   <= i_req.range_high;
            r_sl   <= i_req.slope;
            r_of   <= i_req.offset;
        end
        r_idx  <= n_idx;
        r_num  <= n_num;
        r_den  <= n_den;
        r_any  <= n_any;
        r_m    <= n_m;
        r_prod <= n_prod;
        r_y    <= n_y;
        r_stat <= n_stat;
        r_neg  <= n_neg;
        r_ov   <= n_ov;
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_cnt <= '0;
            r_lv  <= 1'b1;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_lv  <= n_lv;
        end
    end

    assign i_req.ready        = (r_st == S_IDLE);
    assign o_rsp.valid        = (r_st == S_OUT);
    assign o_rsp.result_y     = r_y;
    assign o_rsp.status       = r_stat;
    assign o_rsp.result_valid = r_lv;
endmodule
